>>> src/fps_pkg.sv
// shared types and constants of the frame packet segmenter
package fps_pkg;

	localparam int BITS_W   = 24;                 // frame length in bits
	localparam int TIME_W   = 32;                 // frame duration in microseconds
	localparam int BYTE_SH  = 3;                  // bits to bytes
	localparam int BYTES_W  = BITS_W - BYTE_SH;   // frame length in bytes
	localparam int GAP_W    = 32;
	localparam int PKT_W    = 16;
	localparam int CFG_W    = 16;
	localparam int IN_W     = BITS_W + TIME_W;    // 56, whole bytes
	localparam int OUT_W    = GAP_W + PKT_W;      // 48, whole bytes
	localparam int DIV_W    = 32;                 // dividend and quotient width
	localparam int DSR_W    = 16;                 // divisor and remainder width
	localparam int STEP_W   = $clog2(DIV_W + 1);

	localparam logic [CFG_W-1:0] PKT_SIZE_RST = 16'd1500;

	// controller to datapath
	typedef struct packed {
		logic load;        // take a new frame request
		logic start_cnt;   // divide bytes by packet size
		logic chk;         // latch packet count
		logic start_time;  // divide duration by packet count
		logic emit;        // issue one packet
		logic emit_err;    // issue the too-many result
	} fps_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic too_many;
		logic last_pkt;
		logic out_free;
	} fps_sts_t;

endpackage

>>> src/frame_packet_segmenter.sv
// top level of the frame packet segmenter
//
// cuts each frame request into packets of the configured payload size
// s_axis: one request per frame, tdata = {frame_time_us, frame_bits}
// m_axis: one result per packet, tdata = {packet_bytes, gap_us},
//   tlast marks the final packet, tuser flags a frame needing too many packets
// cfg: write channel for the packet size, always ready, write only while idle
// a packet size of zero acts as one
// the bytes are divided by the size, the count is checked, the duration is
//   divided by the count and then the output register is loaded; both
//   divisions run in turn on the one shared bit-serial divider, and no new
//   frame is taken until the last packet of the current one is issued
// a frame needing more than MAX_PACKETS packets gives one result with
//   tuser set and all other fields zero
// reset clears the state machine and the output valid flag and sets the
//   packet size to 1500; s_axis_tready is high right after reset
// a stalled receiver holds the output register and pauses packet issue;
//   a new frame is taken as soon as the last packet sits in the register
module frame_packet_segmenter import fps_pkg::*; #(
	parameter int MAX_PACKETS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,   // frame_bits[23:0], frame_time_us[55:24]
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata,   // gap_us[31:0], packet_bytes[47:32]
	output logic             m_axis_tlast,
	output logic             m_axis_tuser,   // too_many
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data        // packet_size
);

	fps_cmd_t cmd;
	fps_sts_t sts;

	// the size register takes a write in any cycle
	assign cfg_ready = 1'b1;

	fps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fps_dp #(
		.MAX_PACKETS (MAX_PACKETS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_err   (m_axis_tuser)
	);

endmodule

>>> src/fps_div.sv
// iterative restoring divider, one quotient bit per cycle
module fps_div import fps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DSR_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient,
	output logic [DSR_W-1:0] remainder
);

	logic [DIV_W-1:0]  dq_q;
	logic [DSR_W-1:0]  r_q;
	logic [DSR_W-1:0]  d_q;
	logic [STEP_W-1:0] step_q;
	logic [DSR_W:0]    trial;
	logic [DSR_W:0]    diff;
	logic              fits;

	assign trial = {r_q, dq_q[DIV_W-1]};
	assign diff  = trial - {1'b0, d_q};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (start) begin
			step_q <= STEP_W'(DIV_W);
		end else if (step_q != '0) begin
			step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q <= dividend;
			r_q  <= '0;
			d_q  <= divisor;
		end else if (step_q != '0) begin
			dq_q <= {dq_q[DIV_W-2:0], fits};
			r_q  <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
		end
	end

	// last step runs in this cycle, results valid from the next one
	assign done      = (step_q == STEP_W'(1));
	assign quotient  = dq_q;
	assign remainder = r_q;

endmodule

>>> src/fps_dp.sv
// datapath: size register, divider, packet counters and output register
module fps_dp import fps_pkg::*; #(
	parameter int MAX_PACKETS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fps_cmd_t         cmd,
	output fps_sts_t         sts,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic [IN_W-1:0]  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] out_data,
	output logic             out_last,
	output logic             out_err
);

	localparam int CNT_W = $clog2(MAX_PACKETS + 1);
	localparam int QC_W  = BYTES_W + 1;

	logic [CFG_W-1:0]   packet_size_q;
	logic [PKT_W-1:0]   size;
	logic [BYTES_W-1:0] in_bytes;
	logic [TIME_W-1:0]  time_q;
	logic [BYTES_W-1:0] rem_bytes_q;
	logic [CNT_W-1:0]   left_q;
	logic [CNT_W-1:0]   cnt;
	logic [QC_W-1:0]    cnt_full;
	logic               last;

	logic               div_start;
	logic [DIV_W-1:0]   dividend;
	logic [DSR_W-1:0]   divisor;
	logic               div_done;
	logic [DIV_W-1:0]   div_q;
	logic [DSR_W-1:0]   div_r;

	logic               out_valid_q;
	logic [GAP_W-1:0]   gap_q;
	logic [PKT_W-1:0]   pkt_bytes_q;
	logic               last_q;
	logic               err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_size_q <= PKT_SIZE_RST;
		end else if (cfg_we) begin
			packet_size_q <= cfg_data;
		end
	end

	// a size of zero behaves as one
	assign size     = (packet_size_q == '0) ? PKT_W'(1) : packet_size_q;
	assign in_bytes = in_data[BITS_W-1:BYTE_SH];

	// count = ceil(bytes / size), at least one
	assign cnt_full = div_q[QC_W-1:0] + QC_W'(div_r != '0);
	assign cnt      = (cnt_full == '0) ? CNT_W'(1) : cnt_full[CNT_W-1:0];

	assign div_start = cmd.start_cnt | cmd.start_time;
	assign dividend  = cmd.start_time ? time_q : DIV_W'(in_bytes);
	assign divisor   = cmd.start_time ? DSR_W'(cnt) : size;

	fps_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (dividend),
		.divisor   (divisor),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_r)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			time_q      <= in_data[IN_W-1:BITS_W];
			rem_bytes_q <= in_bytes;
		end else if (cmd.emit) begin
			rem_bytes_q <= rem_bytes_q - BYTES_W'(size);
		end
		if (cmd.chk) begin
			left_q <= cnt;
		end else if (cmd.emit) begin
			left_q <= left_q - 1'b1;
		end
	end

	assign last = (left_q == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.emit_err) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// during emit the divider holds share and extra from the time division
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			gap_q       <= last ? div_q + GAP_W'(div_r) : div_q;
			pkt_bytes_q <= last ? rem_bytes_q[PKT_W-1:0] : size;
			last_q      <= last;
			err_q       <= 1'b0;
		end else if (cmd.emit_err) begin
			gap_q       <= '0;
			pkt_bytes_q <= '0;
			last_q      <= 1'b0;
			err_q       <= 1'b1;
		end
	end

	assign sts.div_done = div_done;
	assign sts.too_many = cnt_full > QC_W'(MAX_PACKETS);
	assign sts.last_pkt = last;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = {pkt_bytes_q, gap_q};
	assign out_last  = last_q;
	assign out_err   = err_q;

endmodule

>>> src/fps_ctrl.sv
// controller state machine of the frame packet segmenter
module fps_ctrl import fps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  fps_sts_t sts,
	output fps_cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_DIV_CNT  = 6'b000010,
		ST_CHK      = 6'b000100,
		ST_DIV_TIME = 6'b001000,
		ST_EMIT     = 6'b010000,
		ST_ERR      = 6'b100000
	} fps_state_t;

	fps_state_t state_q;
	fps_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load      = 1'b1;
					cmd.start_cnt = 1'b1;
					state_d       = ST_DIV_CNT;
				end
			end
			ST_DIV_CNT: begin
				if (sts.div_done) begin
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				cmd.chk = 1'b1;
				if (sts.too_many) begin
					state_d = ST_ERR;
				end else begin
					cmd.start_time = 1'b1;
					state_d        = ST_DIV_TIME;
				end
			end
			ST_DIV_TIME: begin
				if (sts.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.last_pkt) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_ERR: begin
				if (sts.out_free) begin
					cmd.emit_err = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> src/fps_checker.sv
// port-level checks of the frame packet segmenter and their binding
module fps_checker import fps_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata,
	input logic             m_axis_tlast,
	input logic             m_axis_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// a request is followed by divider work, not by another request
	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second request taken during division");

	// the too-many result carries no packet
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0 && !m_axis_tlast)
		else $error("too-many result with nonzero fields");

	// a packet that is not the last one is a full, nonempty packet
	a_full_pkt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser && !m_axis_tlast |->
		m_axis_tdata[OUT_W-1:GAP_W] != '0)
		else $error("empty packet before end of frame");

endmodule

bind frame_packet_segmenter fps_checker u_fps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
